// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define RDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rdq assertion failed");

// Same, with explicit clock and active-low reset.
`define RDQ_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rdq assertion failed");

`endif

// ===== rtl/core/rdq_pkg.sv =====
package rdq_pkg;

  localparam int ACT_W = 3;
  localparam int KEY_W = 31;
  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DEL_FRONT  = 3'd4,
    ACT_DEL_BACK   = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic in_ready;
    logic push;
    logic walk_init;
    logic pop_step;
    logic del_step;
    logic mark_dead;
    logic res_set;
    logic res_ok;
    logic res_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_push;
    logic is_pop;
    logic is_del;
    logic has_room;
    logic empty;
    logic live;
    logic key_hit;
    logic pop_last;
    logic del_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/rdq_if.sv =====
interface rdq_in_if;
  logic                           valid;
  logic                           ready;
  logic [rdq_pkg::ACT_W-1:0]      action;
  logic [rdq_pkg::KEY_W-1:0]      item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface rdq_out_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [rdq_pkg::KEY_W-1:0]      result_value;

  modport source (output valid, output ok, output result_value, input ready);
  modport sink   (input valid, input ok, input result_value, output ready);
endinterface

interface rdq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rdq_pkg::CAP_W-1:0]      capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// ===== rtl/core/rdq_ctrl.sv =====
module rdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rdq_pkg::sts_t sts_i,
  output rdq_pkg::cmd_t cmd_o
);

  rdq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      rdq_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          state_d = rdq_pkg::ST_EXEC;
        end
      end
      rdq_pkg::ST_EXEC: begin
        if (sts_i.is_push) begin
          cmd_o.push    = sts_i.has_room;
          cmd_o.res_set = 1'b1;
          cmd_o.res_ok  = sts_i.has_room;
          state_d       = rdq_pkg::ST_DONE;
        end else if ((sts_i.is_pop || sts_i.is_del) && !sts_i.empty) begin
          cmd_o.walk_init = 1'b1;
          state_d         = rdq_pkg::ST_READ;
        end else begin
          cmd_o.res_set = 1'b1;
          state_d       = rdq_pkg::ST_DONE;
        end
      end
      rdq_pkg::ST_READ: begin
        state_d = rdq_pkg::ST_CHECK;
      end
      rdq_pkg::ST_CHECK: begin
        if (sts_i.is_pop) begin
          cmd_o.pop_step = 1'b1;
          if (sts_i.live) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_ok   = 1'b1;
            cmd_o.res_take = 1'b1;
            state_d        = rdq_pkg::ST_DONE;
          end else if (sts_i.pop_last) begin
            cmd_o.res_set = 1'b1;
            state_d       = rdq_pkg::ST_DONE;
          end else begin
            state_d = rdq_pkg::ST_READ;
          end
        end else begin
          if (sts_i.live && sts_i.key_hit) begin
            cmd_o.mark_dead = 1'b1;
            cmd_o.res_set   = 1'b1;
            cmd_o.res_ok    = 1'b1;
            state_d         = rdq_pkg::ST_DONE;
          end else if (sts_i.del_last) begin
            cmd_o.res_set = 1'b1;
            state_d       = rdq_pkg::ST_DONE;
          end else begin
            cmd_o.del_step = 1'b1;
            state_d        = rdq_pkg::ST_READ;
          end
        end
      end
      rdq_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = rdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/rdq_dp.sv =====
module rdq_dp #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [rdq_pkg::ACT_W-1:0]   action_i,
  input  logic [rdq_pkg::KEY_W-1:0]   item_value_i,
  input  logic                        cfg_valid_i,
  input  logic [rdq_pkg::CAP_W-1:0]   cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_ok_o,
  output logic [rdq_pkg::KEY_W-1:0]   out_value_o,
  input  rdq_pkg::cmd_t               cmd_i,
  output rdq_pkg::sts_t               sts_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = rdq_pkg::KEY_W;

  logic [rdq_pkg::ACT_W-1:0] action_q;
  logic [KW-1:0]             key_q;
  logic [IW-1:0]             front_q, back_q, pos_q;
  logic [CW-1:0]             count_q, left_q;
  logic [rdq_pkg::CAP_W-1:0] cap_q;
  logic                      res_ok_q, out_valid_q, out_ok_q;
  logic [KW-1:0]             res_val_q, out_val_q;
  logic [KW:0]               rd_q;
  logic [KW:0]               mem_q [DEPTH];

  logic [CW-1:0]             cap_eff;
  logic                      from_front, is_push, is_pop, is_del;
  logic [IW-1:0]             push_idx, walk_next, wr_addr;
  logic [KW:0]               wr_data;
  logic                      wr_en, load_in;

  function automatic logic [IW-1:0] step_fwd(logic [IW-1:0] i, logic [CW-1:0] cap);
    logic [CW:0] n;
    n = (CW+1)'(i) + 1'b1;
    return (n >= (CW+1)'(cap)) ? '0 : IW'(n);
  endfunction

  function automatic logic [IW-1:0] step_back(logic [IW-1:0] i, logic [CW-1:0] cap);
    logic [CW-1:0] m;
    m = cap - 1'b1;
    return ((i == '0) || ((CW+1)'(i) >= (CW+1)'(cap))) ? IW'(m) : i - 1'b1;
  endfunction

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  assign is_push    = action_q inside {rdq_pkg::ACT_PUSH_FRONT, rdq_pkg::ACT_PUSH_BACK};
  assign is_pop     = action_q inside {rdq_pkg::ACT_POP_FRONT, rdq_pkg::ACT_POP_BACK};
  assign is_del     = action_q inside {rdq_pkg::ACT_DEL_FRONT, rdq_pkg::ACT_DEL_BACK};
  assign from_front = action_q inside {rdq_pkg::ACT_PUSH_FRONT, rdq_pkg::ACT_POP_FRONT,
                                       rdq_pkg::ACT_DEL_FRONT};

  assign push_idx  = from_front ? step_back(front_q, cap_eff) : step_fwd(back_q, cap_eff);
  assign walk_next = from_front ? step_fwd(pos_q, cap_eff) : step_back(pos_q, cap_eff);
  assign load_in   = cmd_i.in_ready && in_valid_i;

  assign wr_en   = cmd_i.push || cmd_i.mark_dead;
  assign wr_addr = cmd_i.push ? push_idx : pos_q;
  assign wr_data = cmd_i.push ? {1'b1, key_q} : {1'b0, rd_q[KW-1:0]};

  assign sts_o.in_valid = in_valid_i;
  assign sts_o.is_push  = is_push;
  assign sts_o.is_pop   = is_pop;
  assign sts_o.is_del   = is_del;
  assign sts_o.has_room = count_q < cap_eff;
  assign sts_o.empty    = count_q == '0;
  assign sts_o.live     = rd_q[KW];
  assign sts_o.key_hit  = rd_q[KW-1:0] == key_q;
  assign sts_o.pop_last = count_q == CW'(1);
  assign sts_o.del_last = left_q == CW'(1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_value_o = out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      cap_q       <= rdq_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.push) begin
        count_q <= count_q + 1'b1;
        if (from_front) begin
          front_q <= push_idx;
          if (count_q == '0) begin
            back_q <= push_idx;
          end
        end else begin
          back_q <= push_idx;
          if (count_q == '0) begin
            front_q <= push_idx;
          end
        end
      end
      if (cmd_i.pop_step) begin
        count_q <= count_q - 1'b1;
        if (from_front) begin
          front_q <= walk_next;
        end else begin
          back_q <= walk_next;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      action_q <= action_i;
      key_q    <= item_value_i;
    end
    if (cmd_i.walk_init) begin
      pos_q  <= from_front ? front_q : back_q;
      left_q <= count_q;
    end
    if (cmd_i.pop_step || cmd_i.del_step) begin
      pos_q <= walk_next;
    end
    if (cmd_i.del_step) begin
      left_q <= left_q - 1'b1;
    end
    if (cmd_i.res_set) begin
      res_ok_q  <= cmd_i.res_ok;
      res_val_q <= cmd_i.res_take ? rd_q[KW-1:0] : '0;
    end
    if (cmd_i.out_load) begin
      out_ok_q  <= res_ok_q;
      out_val_q <= res_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[pos_q];
  end

endmodule

// ===== rtl/core/ring_deque_with_lazy_delete_unit.sv =====
// Push: the input beat is taken in IDLE, decoded in EXEC (one memory write), then loaded out in DONE.
// Pop / delete: walks k slots, k = slots visited (1..entry count); each slot
// costs one registered read of the one-write, one-read entry memory plus one check.
// One item at a time: the next input beat is taken only after the last result is loaded out.
// Reset clears front/back indices, count and output valid, sets capacity to 1024;
// the entry memory is not cleared and there is no clearing pass.
module ring_deque_with_lazy_delete_unit #(
  parameter int DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rdq_in_if.sink     in_i,
  rdq_out_if.source  out_o,
  rdq_cfg_if.sink    cfg_i
);

  rdq_pkg::cmd_t cmd;
  rdq_pkg::sts_t sts;

  assign in_i.ready  = cmd.in_ready;
  assign cfg_i.ready = 1'b1;

  rdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .action_i     (in_i.action),
    .item_value_i (in_i.item_value),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_data_i   (cfg_i.capacity_in_use),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_ok_o     (out_o.ok),
    .out_value_o  (out_o.result_value),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ===== rtl/core/rdq_chk.sv =====
`include "assert_macros.svh"

module rdq_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_ok_i,
  input logic [rdq_pkg::KEY_W-1:0] out_result_value_i
);

  `RDQ_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `RDQ_ASSERT(a_one_in_flight, in_valid_i && in_ready_i |=> !in_ready_i)
  `RDQ_ASSERT(a_fail_zero, out_valid_i && !out_ok_i |-> out_result_value_i == '0)
  `RDQ_ASSERT(a_res_after_work, $rose(out_valid_i) |-> $past(!in_ready_i))

endmodule

bind ring_deque_with_lazy_delete_unit rdq_chk u_rdq_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_ok_i           (out_o.ok),
  .out_result_value_i (out_o.result_value)
);

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [rdq_pkg::ACT_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [rdq_pkg::ACT_W-1:0] ACT_SPARE_B = 3'd7;

  typedef logic [rdq_pkg::KEY_W-1:0]     key_t;
  typedef logic [rdq_pkg::CAP_W-1:0]     cap_t;
  typedef logic [$clog2(RING_DEPTH)-1:0] slot_t;

  typedef struct packed {
    logic ok;
    key_t key;
  } deque_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rdq_in_if  in_if ();
  rdq_out_if out_if ();
  rdq_cfg_if cfg_if ();

  ring_deque_with_lazy_delete_unit #(
    .DEPTH(RING_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // Shadow deque state
  key_t             slot_key [RING_DEPTH];
  bit               slot_live [RING_DEPTH];
  bit               slot_written [RING_DEPTH];
  int unsigned      head_idx = 0;
  int unsigned      tail_idx = 0;
  int unsigned      held = 0;
  cap_t             cap_reg = rdq_pkg::CAP_RESET;

  deque_reply_t     owed_replies [$];
  key_t             recent_keys [$];
  int unsigned      fail_count = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      src_idle_pct = 8;
  int unsigned      sink_idle_pct = 82;
  logic             sink_hold = 1'b0;
  event             sink_hold_ev;

  function automatic int unsigned ring_size();
    if (cap_reg == '0) return 1;
    if (32'(cap_reg) > RING_DEPTH) return RING_DEPTH;
    return 32'(cap_reg);
  endfunction

  function automatic int unsigned step_up(int unsigned i, int unsigned c);
    return (i + 1 >= c) ? 0 : i + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned i, int unsigned c);
    return (i == 0 || i >= c) ? c - 1 : i - 1;
  endfunction

  // True if the walk for this action would reach a slot never written.
  function automatic bit hits_blank(logic [rdq_pkg::ACT_W-1:0] act, key_t key);
    int unsigned c, pos, left;
    bit          fwd;
    bit          is_pop;
    c = ring_size();
    fwd = (act == rdq_pkg::ACT_POP_FRONT || act == rdq_pkg::ACT_DEL_FRONT);
    is_pop = (act == rdq_pkg::ACT_POP_FRONT || act == rdq_pkg::ACT_POP_BACK);
    if (!(act inside {rdq_pkg::ACT_POP_FRONT, rdq_pkg::ACT_POP_BACK,
                      rdq_pkg::ACT_DEL_FRONT, rdq_pkg::ACT_DEL_BACK})) return 1'b0;
    pos = fwd ? head_idx : tail_idx;
    for (left = held; left > 0; left--) begin
      if (!slot_written[slot_t'(pos)]) return 1'b1;
      if (slot_live[slot_t'(pos)] && (is_pop || slot_key[slot_t'(pos)] == key)) return 1'b0;
      pos = fwd ? step_up(pos, c) : step_down(pos, c);
    end
    return 1'b0;
  endfunction

  function automatic deque_reply_t deque_step(logic [rdq_pkg::ACT_W-1:0] act, key_t key);
    deque_reply_t r;
    int unsigned  c, slot, pos, left;
    r = '0;
    c = ring_size();
    case (act)
      rdq_pkg::ACT_PUSH_FRONT, rdq_pkg::ACT_PUSH_BACK: begin
        if (held < c) begin
          if (act == rdq_pkg::ACT_PUSH_FRONT) begin
            head_idx = step_down(head_idx, c);
            slot = head_idx;
            if (held == 0) tail_idx = slot;
          end else begin
            tail_idx = step_up(tail_idx, c);
            slot = tail_idx;
            if (held == 0) head_idx = slot;
          end
          slot_key[slot_t'(slot)] = key;
          slot_live[slot_t'(slot)] = 1'b1;
          slot_written[slot_t'(slot)] = 1'b1;
          held++;
          r.ok = 1'b1;
        end
      end
      rdq_pkg::ACT_POP_FRONT, rdq_pkg::ACT_POP_BACK: begin
        while (held > 0 && !r.ok) begin
          slot = (act == rdq_pkg::ACT_POP_FRONT) ? head_idx : tail_idx;
          if (act == rdq_pkg::ACT_POP_FRONT) head_idx = step_up(head_idx, c);
          else tail_idx = step_down(tail_idx, c);
          held--;
          if (slot_live[slot_t'(slot)]) begin
            r.ok = 1'b1;
            r.key = slot_key[slot_t'(slot)];
          end
        end
      end
      rdq_pkg::ACT_DEL_FRONT, rdq_pkg::ACT_DEL_BACK: begin
        pos = (act == rdq_pkg::ACT_DEL_FRONT) ? head_idx : tail_idx;
        left = held;
        while (left > 0 && !r.ok) begin
          if (slot_live[slot_t'(pos)] && slot_key[slot_t'(pos)] == key) begin
            slot_live[slot_t'(pos)] = 1'b0;
            r.ok = 1'b1;
          end else begin
            pos = (act == rdq_pkg::ACT_DEL_FRONT) ? step_up(pos, c) : step_down(pos, c);
            left--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    deque_reply_t exp_reply;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (owed_replies.size() == 0) begin
        $error("result beat with nothing outstanding: ok %0b result_value 0x%0h",
               out_if.ok, out_if.result_value);
        fail_count++;
      end else begin
        exp_reply = owed_replies.pop_front();
        if (out_if.ok !== exp_reply.ok) begin
          $error("ok: expected %0b, got %0b", exp_reply.ok, out_if.ok);
          fail_count++;
        end
        if (out_if.result_value !== exp_reply.key) begin
          $error("result_value: expected 0x%0h, got 0x%0h", exp_reply.key,
                 out_if.result_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= !sink_hold && ($urandom_range(99, 0) >= sink_idle_pct);
  end

  initial begin
    forever begin
      @(sink_hold_ev);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      sink_hold <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_op(input logic [rdq_pkg::ACT_W-1:0] act, input key_t key);
    logic [rdq_pkg::ACT_W-1:0] a;
    a = hits_blank(act, key) ? rdq_pkg::ACT_PUSH_BACK : act;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= a;
    in_if.item_value <= key;
    do @(posedge clk_i); while (!in_if.ready);
    owed_replies.push_back(deque_step(a, key));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (owed_replies.size() != 0);
  endtask

  task automatic write_capacity(input cap_t value);
    drain();
    cfg_if.valid           <= 1'b1;
    cfg_if.capacity_in_use <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cap_reg = value;
  endtask

  task automatic random_op();
    int unsigned               pick;
    logic [rdq_pkg::ACT_W-1:0] act;
    key_t                      key;
    pick = $urandom_range(99, 0);
    if (pick < 20) act = rdq_pkg::ACT_PUSH_FRONT;
    else if (pick < 40) act = rdq_pkg::ACT_PUSH_BACK;
    else if (pick < 55) act = rdq_pkg::ACT_POP_FRONT;
    else if (pick < 70) act = rdq_pkg::ACT_POP_BACK;
    else if (pick < 82) act = rdq_pkg::ACT_DEL_FRONT;
    else if (pick < 94) act = rdq_pkg::ACT_DEL_BACK;
    else if (pick < 97) act = ACT_SPARE_A;
    else act = ACT_SPARE_B;
    case ($urandom_range(3, 0))
      0: key = key_t'($urandom());
      1: key = key_t'($urandom_range(15, 0));
      2: key = (recent_keys.size() != 0) ?
               recent_keys[$urandom_range(recent_keys.size() - 1, 0)] : '0;
      default: key = $urandom_range(1, 0) ? '1 : '0;
    endcase
    if (act == rdq_pkg::ACT_PUSH_FRONT || act == rdq_pkg::ACT_PUSH_BACK) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 32) void'(recent_keys.pop_front());
    end
    send_op(act, key);
  endtask

  task automatic test_empty_ring();
    send_op(rdq_pkg::ACT_POP_FRONT, '0);
    send_op(rdq_pkg::ACT_POP_BACK, '1);
    send_op(rdq_pkg::ACT_DEL_FRONT, '0);
    send_op(rdq_pkg::ACT_DEL_BACK, '1);
    send_op(ACT_SPARE_A, 31'd1);
    send_op(ACT_SPARE_B, 31'd2);
  endtask

  task automatic test_push_pop();
    send_op(rdq_pkg::ACT_PUSH_BACK, '1);
    send_op(rdq_pkg::ACT_PUSH_FRONT, '0);
    send_op(rdq_pkg::ACT_PUSH_BACK, 31'd5);
    send_op(rdq_pkg::ACT_PUSH_FRONT, 31'd5);
    send_op(rdq_pkg::ACT_DEL_FRONT, 31'd5);
    send_op(rdq_pkg::ACT_DEL_BACK, 31'd5);
    send_op(rdq_pkg::ACT_DEL_BACK, 31'd77);
    send_op(rdq_pkg::ACT_POP_FRONT, '0);
    send_op(rdq_pkg::ACT_POP_BACK, '0);
    send_op(rdq_pkg::ACT_POP_FRONT, '0);
    // all entries dead: pop discards them and fails
    send_op(rdq_pkg::ACT_PUSH_FRONT, 31'd9);
    send_op(rdq_pkg::ACT_PUSH_BACK, 31'd9);
    send_op(rdq_pkg::ACT_DEL_FRONT, 31'd9);
    send_op(rdq_pkg::ACT_DEL_BACK, 31'd9);
    send_op(rdq_pkg::ACT_POP_BACK, '0);
    send_op(rdq_pkg::ACT_POP_FRONT, '0);
  endtask

  task automatic test_capacity_limits();
    write_capacity('0);
    send_op(rdq_pkg::ACT_PUSH_BACK, 31'd3);
    send_op(rdq_pkg::ACT_PUSH_FRONT, 31'd4);
    send_op(rdq_pkg::ACT_POP_FRONT, '0);
    write_capacity(cap_t'(2));
    send_op(rdq_pkg::ACT_PUSH_FRONT, 31'd11);
    send_op(rdq_pkg::ACT_PUSH_FRONT, 31'd12);
    send_op(rdq_pkg::ACT_PUSH_FRONT, 31'd13);
    send_op(rdq_pkg::ACT_POP_BACK, '0);
    write_capacity(cap_t'(8));
    repeat (6) send_op(rdq_pkg::ACT_PUSH_BACK, key_t'($urandom()));
    // shrink below the held count
    write_capacity(cap_t'(3));
    send_op(rdq_pkg::ACT_PUSH_BACK, 31'd1);
    send_op(rdq_pkg::ACT_POP_FRONT, '0);
    send_op(rdq_pkg::ACT_POP_BACK, '0);
    send_op(rdq_pkg::ACT_DEL_FRONT, 31'd12);
    write_capacity('1);
    send_op(rdq_pkg::ACT_POP_FRONT, '0);
    send_op(rdq_pkg::ACT_PUSH_FRONT, 31'd21);
    send_op(rdq_pkg::ACT_POP_BACK, '0);
    send_op(rdq_pkg::ACT_POP_BACK, '0);
  endtask

  task automatic test_output_stall();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    write_capacity(cap_t'(16));
    -> sink_hold_ev;
    repeat (24) random_op();
    drain();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned dst_pct,
                                     input int unsigned n_items);
    int unsigned done_items, span, sel;
    src_idle_pct = src_pct;
    sink_idle_pct <= dst_pct;
    done_items = 0;
    while (done_items < n_items) begin
      sel = $urandom_range(99, 0);
      if (sel < 3) write_capacity('0);
      else if (sel < 6) write_capacity('1);
      else if (sel < 10) write_capacity(cap_t'(RING_DEPTH));
      else if (sel < 20) write_capacity(cap_t'($urandom_range(RING_DEPTH, 13)));
      else write_capacity(cap_t'($urandom_range(12, 1)));
      span = $urandom_range(150, 50);
      repeat (span) random_op();
      done_items += span;
    end
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.action           <= '0;
    in_if.item_value       <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.capacity_in_use <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_ring();
    test_push_pop();
    test_capacity_limits();
    test_output_stall();
    test_random_traffic(8, 82, 650);
    test_random_traffic(82, 8, 650);
    test_random_traffic(0, 0, 700);

    drain();
    repeat (20) @(posedge clk_i);
    if (owed_replies.size() != 0) begin
      $error("%0d results never arrived", owed_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
